// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ouks_pkg.sv -----
package ouks_pkg;

  localparam int KEY_FIELD_W = 32;
  localparam int POS_W       = 4;
  localparam int CNT_FIELD_W = 5;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_READ   = 3'd4,
    CMD_LIST   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_READ_WAIT,
    ST_LIST
  } state_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [KEY_FIELD_W-1:0] key;
    logic [POS_W-1:0]       position;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [KEY_FIELD_W-1:0] entry_value;
    logic [CNT_FIELD_W-1:0] entry_count;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    rd_scan;
    logic    rd_pos;
    logic    seek_hit;
    logic    shift_wr;
    logic    append;
    logic    count_dec;
    logic    count_clr;
    logic    emit;
    status_t emit_status;
    logic    emit_data;
    logic    emit_last;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic hit;
    logic idx_end;
    logic full;
    logic empty;
    logic pos_ok;
    logic rv;
  } dp_stat_t;

endpackage

// ----- sv/ouks_ram.sv -----
module ouks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/ouks_ctrl.sv -----
module ouks_ctrl
  import ouks_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.emit_status = STS_OK;
    busy            = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.cmd)
          CMD_ADD, CMD_REMOVE, CMD_FIND: begin
            state_nxt = ST_SCAN;
          end
          CMD_CLEAR: begin
            cmd.count_clr = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_nxt     = ST_IDLE;
          end
          CMD_READ: begin
            if (stat.pos_ok) begin
              cmd.rd_pos = 1'b1;
              state_nxt  = ST_READ_WAIT;
            end else begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_RANGE;
              cmd.emit_last   = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end
          CMD_LIST: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_NOT_FOUND;
              cmd.emit_last   = 1'b1;
              state_nxt       = ST_IDLE;
            end else begin
              state_nxt = ST_LIST;
            end
          end
          default: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_nxt     = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (stat.hit) begin
          case (stat.cmd)
            CMD_REMOVE: begin
              cmd.seek_hit = 1'b1;
              state_nxt    = ST_SHIFT;
            end
            CMD_ADD: begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_PRESENT;
              cmd.emit_last   = 1'b1;
              state_nxt       = ST_IDLE;
            end
            default: begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              state_nxt     = ST_IDLE;
            end
          endcase
        end else if (stat.idx_end) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
          if (stat.cmd == CMD_ADD) begin
            if (stat.full) begin
              cmd.emit_status = STS_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end else begin
            cmd.emit_status = STS_NOT_FOUND;
          end
        end else begin
          cmd.rd_scan = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd.rd_scan  = !stat.idx_end;
        cmd.shift_wr = stat.rv;
        if (stat.idx_end && !stat.rv) begin
          cmd.count_dec = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ_WAIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_data = 1'b1;
        cmd.emit_last = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_LIST: begin
        cmd.rd_scan = !stat.idx_end;
        if (stat.rv) begin
          cmd.emit      = 1'b1;
          cmd.emit_data = 1'b1;
          cmd.emit_last = stat.idx_end;
        end
        if (stat.idx_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/ouks_dp.sv -----
module ouks_dp
  import ouks_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;

  cmd_t             cmd_r;
  logic [KW-1:0]    key_r;
  logic [POS_W-1:0] pos_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    idx_nxt;
  logic             rv_r;
  logic [AW-1:0]    ra_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [KW-1:0]         rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KW-1:0]         wr_data;
  logic [AW+POS_W-1:0]   pos_x;
  logic [CW+POS_W-1:0]   pos_cmp;
  logic [CW+POS_W-1:0]   count_cmp;
  logic [CW+CNT_FIELD_W-1:0] count_x;
  logic [KW+KEY_FIELD_W-1:0] value_x;

  ouks_ram #(
    .WIDTH(KW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    pos_x     = (AW + POS_W)'(pos_r);
    pos_cmp   = (CW + POS_W)'(pos_r);
    count_cmp = (CW + POS_W)'(count_r);
    rd_en     = cmd.rd_scan | cmd.rd_pos;
    rd_addr   = cmd.rd_pos ? pos_x[AW-1:0] : idx_r[AW-1:0];
    wr_en     = cmd.append | cmd.shift_wr;
    wr_addr   = cmd.append ? count_r[AW-1:0] : ra_r - AW'(1);
    wr_data   = cmd.append ? key_r : rd_data;

    count_nxt = count_r;
    if (cmd.count_clr) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CW'(1);
    end

    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.seek_hit) begin
      idx_nxt = CW'(ra_r) + CW'(1);
    end else if (cmd.rd_scan) begin
      idx_nxt = idx_r + CW'(1);
    end

    count_x = (CW + CNT_FIELD_W)'(count_nxt);
    value_x = (KW + KEY_FIELD_W)'(rd_data);

    stat.cmd     = cmd_r;
    stat.hit     = rv_r && (rd_data == key_r);
    stat.idx_end = (idx_r == count_r);
    stat.full    = (count_r >= CW'(CAPACITY));
    stat.empty   = (count_r == '0);
    stat.pos_ok  = (pos_cmp < count_cmp);
    stat.rv      = rv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rv_r        <= rd_en;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_item.cmd;
      key_r <= in_item.key[KW-1:0];
      pos_r <= in_item.position;
    end
    if (rd_en) begin
      ra_r <= rd_addr;
    end
    if (cmd.emit) begin
      out_item_r.status      <= cmd.emit_status;
      out_item_r.entry_value <= cmd.emit_data ? value_x[KEY_FIELD_W-1:0] : '0;
      out_item_r.entry_count <= count_x[CNT_FIELD_W-1:0];
      out_item_r.last        <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- sv/ordered_unique_key_set_core.sv -----
// steps: find, add and list walk the stored keys from accept to the last result; find and add
// stop early when they hit; remove scans for the key, then shifts the later entries down
// read fetches the entry at the given position; clear and unused codes answer from dispatch
// throughput: one item at a time, the next accept can fall on the edge that takes the last
// result; the single read port of the entry ram is walked once per stored key
// reset: synchronous active low, empties the set; entries are not cleared and need no pass
module ordered_unique_key_set_core
  import ouks_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ouks_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (dp_stat),
    .cmd  (dp_cmd)
  );

  ouks_dp #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

// ----- sv/ouks_checker.sv -----
`include "assert_macros.svh"

module ouks_checker
  import ouks_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  logic accept;
  assign accept = start && !busy;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy, "busy low after accept")
  `ASSERT_NEXT(a_list_streams, clk, rst_n, out_valid && !out_item.last, out_valid, "gap in list")
  `ASSERT_IMPLIES(a_idle_at_last, clk, rst_n, out_valid && out_item.last, !busy, "busy at last")
  `ASSERT_IMPLIES(a_value_zero, clk, rst_n, out_valid && (out_item.status != STS_OK),
    out_item.entry_value == '0, "value on failed item")
  `ASSERT_IMPLIES(a_full_count, clk, rst_n, out_valid && (out_item.status == STS_FULL),
    out_item.entry_count == CNT_FIELD_W'(CAPACITY), "full with room left")

endmodule

bind ordered_unique_key_set_core ouks_checker #(.CAPACITY(CAPACITY)) u_ouks_checker (.*);
